// ----- rtl/tdp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_pkg: shared types and constants for the trial-division prime test
// Widths, search constants and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package tdp_pkg;

  // Width of the candidate, two's complement
  localparam int VALUE_WIDTH   = 32;
  // Magnitude bits of a non-negative candidate
  localparam int MAG_WIDTH     = VALUE_WIDTH - 1;
  // Square of the divisor is kept at full product width
  localparam int SQ_WIDTH      = 2 * VALUE_WIDTH;
  // Bit counter of the remainder unit, able to hold MAG_WIDTH itself
  localparam int MOD_CNT_WIDTH = $clog2(MAG_WIDTH + 1);

  // Smallest divisor; also the only even prime
  localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR     = VALUE_WIDTH'(2);
  // Odd search starts here and advances by two
  localparam logic [VALUE_WIDTH-1:0] FIRST_ODD_DIVISOR = VALUE_WIDTH'(3);
  localparam logic [VALUE_WIDTH-1:0] DIVISOR_STEP      = VALUE_WIDTH'(2);
  localparam logic [SQ_WIDTH-1:0]    FIRST_ODD_SQUARE  = SQ_WIDTH'(9);
  // (d + 2)^2 - d^2 = 4d + 4
  localparam logic [SQ_WIDTH-1:0]    SQ_STEP_BIAS      = SQ_WIDTH'(4);

  // Controller to datapath
  typedef struct packed {
    logic load;          // capture the candidate
    logic init_search;   // divisor = 3, square = 9
    logic mod_start;     // start candidate mod divisor
    logic step_divisor;  // divisor += 2, square updated
  } tdp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic below_two;     // negative, zero or one
    logic is_two;
    logic is_even;
    logic bound_passed;  // divisor squared exceeds candidate
    logic mod_done;      // remainder is ready (one-cycle pulse)
    logic mod_zero;      // remainder is zero, valid with mod_done
  } tdp_status_t;

endpackage
`default_nettype wire

// ----- rtl/tdp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_if: valid/ready channels of the prime test
// Candidate channel in, verdict channel out. A transaction completes on a
// rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface tdp_cand_if;
  import tdp_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface tdp_res_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface
`default_nettype wire

// ----- rtl/tdp_mod_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_mod_unit: bit-serial remainder unit
// Restoring shift-subtract, one dividend bit per cycle, MSB first. The
// divisor must hold steady until done pulses.
// ----------------------------------------------------------------------------
module tdp_mod_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [tdp_pkg::MAG_WIDTH-1:0]   dividend,
  input  wire logic [tdp_pkg::VALUE_WIDTH-1:0] divisor,
  output logic                               done,
  output logic                               zero
);
  import tdp_pkg::*;

  logic                     busy_r;
  logic                     done_r;
  logic [MOD_CNT_WIDTH-1:0] cnt_r;
  logic [MAG_WIDTH-1:0]     bits_r;
  logic [VALUE_WIDTH-1:0]   rem_r;

  logic [VALUE_WIDTH:0]     trial;
  logic [VALUE_WIDTH:0]     diff;
  logic [VALUE_WIDTH-1:0]   rem_nxt;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial   = {rem_r, bits_r[MAG_WIDTH-1]};
    diff    = trial - {1'b0, divisor};
    rem_nxt = diff[VALUE_WIDTH] ? trial[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
  end

  // Control: count the bits, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= MOD_CNT_WIDTH'(MAG_WIDTH);
    end else if (busy_r) begin
      cnt_r <= cnt_r - MOD_CNT_WIDTH'(1);
      if (cnt_r == MOD_CNT_WIDTH'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Payload: partial remainder and remaining dividend bits
  always_ff @(posedge clk) begin
    if (start) begin
      bits_r <= dividend;
      rem_r  <= '0;
    end else if (busy_r) begin
      bits_r <= {bits_r[MAG_WIDTH-2:0], 1'b0};
      rem_r  <= rem_nxt;
    end
  end

  assign done = done_r;
  assign zero = (rem_r == '0);

  // done only follows the last busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("remainder done without a preceding busy cycle");

endmodule
`default_nettype wire

// ----- rtl/tdp_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_datapath: candidate, divisor and bound registers of the prime test
// Holds the candidate, walks odd divisors with an incrementally updated
// square, and runs the remainder unit on command.
// ----------------------------------------------------------------------------
module tdp_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic signed [tdp_pkg::VALUE_WIDTH-1:0] candidate,
  input  wire tdp_pkg::tdp_cmd_t                   cmd,
  output tdp_pkg::tdp_status_t                     status
);
  import tdp_pkg::*;

  logic [VALUE_WIDTH-1:0] v_r;
  logic [VALUE_WIDTH-1:0] d_r;
  logic [SQ_WIDTH-1:0]    sq_r;
  logic                   mod_done;
  logic                   mod_zero;

  // Capture the candidate; advance divisor and its square together
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r <= VALUE_WIDTH'(candidate);
    end
    if (cmd.init_search) begin
      d_r  <= FIRST_ODD_DIVISOR;
      sq_r <= FIRST_ODD_SQUARE;
    end else if (cmd.step_divisor) begin
      d_r  <= d_r + DIVISOR_STEP;
      sq_r <= sq_r + SQ_WIDTH'({d_r, 2'b00}) + SQ_STEP_BIAS;
    end
  end

  tdp_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (v_r[MAG_WIDTH-1:0]),
    .divisor  (d_r),
    .done     (mod_done),
    .zero     (mod_zero)
  );

  // Classify the candidate and report search progress
  always_comb begin
    status.below_two    = v_r[VALUE_WIDTH-1] || (v_r < FIRST_DIVISOR);
    status.is_two       = (v_r == FIRST_DIVISOR);
    status.is_even      = !v_r[0];
    status.bound_passed = (sq_r > SQ_WIDTH'(v_r));
    status.mod_done     = mod_done;
    status.mod_zero     = mod_zero;
  end

endmodule
`default_nettype wire

// ----- rtl/tdp_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_ctrl: sequencer of the prime test
// Accepts one candidate, steers the divisor search and holds the verdict
// in the output register until the sink takes it.
// ----------------------------------------------------------------------------
module tdp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_is_prime,
  output tdp_pkg::tdp_cmd_t        cmd,
  input  wire tdp_pkg::tdp_status_t status
);
  import tdp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_BOUND,
    S_DIVIDE,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   verdict_r, verdict_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_is_prime_r, out_is_prime_nxt;

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

  // Next state, commands and output register update
  always_comb begin
    state_nxt        = state_r;
    verdict_nxt      = verdict_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_is_prime_nxt = out_is_prime_r;
    cmd              = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        if (status.below_two) begin
          verdict_nxt = 1'b0;
          state_nxt   = S_FINISH;
        end else if (status.is_two) begin
          verdict_nxt = 1'b1;
          state_nxt   = S_FINISH;
        end else if (status.is_even) begin
          verdict_nxt = 1'b0;
          state_nxt   = S_FINISH;
        end else begin
          cmd.init_search = 1'b1;
          state_nxt       = S_BOUND;
        end
      end
      S_BOUND: begin
        if (status.bound_passed) begin
          verdict_nxt = 1'b1;
          state_nxt   = S_FINISH;
        end else begin
          cmd.mod_start = 1'b1;
          state_nxt     = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (status.mod_done) begin
          if (status.mod_zero) begin
            verdict_nxt = 1'b0;
            state_nxt   = S_FINISH;
          end else begin
            cmd.step_divisor = 1'b1;
            state_nxt        = S_BOUND;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = verdict_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    verdict_r      <= verdict_nxt;
    out_is_prime_r <= out_is_prime_nxt;
  end

  // One candidate in flight: no second accept right after the first
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while busy");

  // A new verdict is posted only on leaving the finish state
  a_post_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("verdict posted outside the finish state");

  // A finished remainder always moves the search on
  a_divide_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIVIDE && status.mod_done |=> state_r != S_DIVIDE)
    else $error("remainder result ignored");

endmodule
`default_nettype wire

// ----- rtl/trial_division_prime_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test by trial division
// Top level: controller, datapath and the valid/ready channels.
// ----------------------------------------------------------------------------
// Takes a signed candidate and returns is_prime = 1 when it is prime. Values
// of one or less (zero and negatives included) and even values other than
// two are settled in the classify state right after the transaction, and the
// verdict is posted from the finish state once the output register is free.
// Odd candidates are divided by 3, 5, 7 and onward while the divisor squared
// does not exceed the candidate; each divisor takes a full pass of the
// bit-serial remainder unit, which sets the rate. A prime near 2^31 takes
// about 23,170 divisors; a composite stops at its smallest odd factor. One
// candidate is worked at a time; the verdict sits in an output register, so
// a new candidate is taken while the previous verdict waits for the sink.
module trial_division_prime_test (
  input wire logic  clk,
  input wire logic  rst_n,
  tdp_cand_if.sink  in_ch,
  tdp_res_if.source out_ch
);
  import tdp_pkg::*;

  tdp_cmd_t    cmd;
  tdp_status_t status;

  tdp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_is_prime (out_ch.is_prime),
    .cmd          (cmd),
    .status       (status)
  );

  tdp_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .candidate (in_ch.candidate),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire
